### src/qmi_pkg.sv
// Shared types and constants for the queue with middle insertion.
`default_nettype none
package qmi_pkg;

  // Default number of entries in each ring half
  localparam int DEFAULT_CAPACITY = 1024;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 11;

  // Command codes; the fourth code is a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer phases: accept a command, then finish it
  typedef enum logic {
    PH_IDLE   = 1'b0,
    PH_FINISH = 1'b1
  } phase_t;

endpackage
`default_nettype wire

### src/qmi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module qmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/qmi_ctrl.sv
// Ring pointer bookkeeping and two-phase sequencer for the two queue halves.
`default_nettype none
module qmi_ctrl #(
  parameter int CAPACITY = qmi_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [qmi_pkg::CMD_W-1:0]     command,
  input  wire logic [qmi_pkg::DATA_W-1:0]    value,
  output logic                               busy,
  output logic                               done,
  output logic [qmi_pkg::DATA_W-1:0]         popped_value,
  output logic [qmi_pkg::STATUS_W-1:0]       status,
  output logic [qmi_pkg::OCC_W-1:0]          occupancy,
  output logic                               front_we,
  output logic [$clog2(CAPACITY)-1:0]        front_waddr,
  output logic [qmi_pkg::DATA_W-1:0]         front_wdata,
  output logic [$clog2(CAPACITY)-1:0]        front_raddr,
  input  wire logic [qmi_pkg::DATA_W-1:0]    front_rdata,
  output logic                               back_we,
  output logic [$clog2(CAPACITY)-1:0]        back_waddr,
  output logic [qmi_pkg::DATA_W-1:0]         back_wdata,
  output logic [$clog2(CAPACITY)-1:0]        back_raddr,
  input  wire logic [qmi_pkg::DATA_W-1:0]    back_rdata
);

  import qmi_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  // Ring index plus offset (offset at most CAPACITY), wrapped once
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Ring index plus one, wrapped
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(CAPACITY - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  // Ring index minus one, wrapped
  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == '0) begin
      res = IDX_W'(CAPACITY - 1);
    end else begin
      res = idx - 1'b1;
    end
    return res;
  endfunction

  phase_t           state, state_next;
  logic [IDX_W-1:0] fstart, fstart_next;
  logic [CNT_W-1:0] fcount, fcount_next;
  logic [IDX_W-1:0] bstart, bstart_next;
  logic [CNT_W-1:0] bcount, bcount_next;
  logic             pend_pop, pend_pop_next;
  logic             pend_move, pend_move_next;
  logic [IDX_W-1:0] ftail, ftail_next;
  status_t          status_q, status_next;
  logic [OCC_W-1:0] occ_q, occ_next;

  logic             accept;
  logic [SUM_W-1:0] total;
  logic             full;
  logic             balanced;
  logic             f_we0;
  logic [IDX_W-1:0] f_waddr0;

  assign accept   = (state == PH_IDLE) && start;
  assign total    = SUM_W'(fcount) + SUM_W'(bcount);
  assign full     = (total >= SUM_W'(CAPACITY));
  assign balanced = (fcount == bcount);

  // Heads are read every cycle; data is used in the finish phase
  assign front_raddr = fstart;
  assign back_raddr  = bstart;

  // First phase: update pointers, issue writes, note pending work
  always_comb begin
    fstart_next    = fstart;
    fcount_next    = fcount;
    bstart_next    = bstart;
    bcount_next    = bcount;
    pend_pop_next  = pend_pop;
    pend_move_next = pend_move;
    ftail_next     = ftail;
    status_next    = status_q;
    f_we0          = 1'b0;
    f_waddr0       = wrap_add(fstart, fcount);
    back_we        = 1'b0;
    back_waddr     = wrap_add(bstart, bcount);
    back_wdata     = value;
    if (accept) begin
      pend_pop_next  = 1'b0;
      pend_move_next = 1'b0;
      ftail_next     = wrap_add(fstart, fcount);
      status_next    = ST_OK;
      case (command)
        CMD_PUSH: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            back_we = 1'b1;
            if (!balanced) begin
              bcount_next = bcount + 1'b1;
            end else if (bcount == '0) begin
              // Empty back half: the new value goes straight to the front tail
              f_we0       = 1'b1;
              fcount_next = fcount + 1'b1;
              bstart_next = wrap_inc(bstart);
            end else begin
              // Move the back head to the front tail in the finish phase
              pend_move_next = 1'b1;
              fcount_next    = fcount + 1'b1;
              bstart_next    = wrap_inc(bstart);
            end
          end
        end
        CMD_INSERT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            back_we    = 1'b1;
            back_waddr = wrap_dec(bstart);
            if (balanced) begin
              // The inserted value becomes the front tail at once
              f_we0       = 1'b1;
              fcount_next = fcount + 1'b1;
            end else begin
              bstart_next = wrap_dec(bstart);
              bcount_next = bcount + 1'b1;
            end
          end
        end
        CMD_POP: begin
          if (fcount == '0) begin
            status_next = ST_EMPTY;
          end else begin
            pend_pop_next = 1'b1;
            fstart_next   = wrap_inc(fstart);
            if (balanced) begin
              pend_move_next = 1'b1;
              bstart_next    = wrap_inc(bstart);
              bcount_next    = bcount - 1'b1;
            end else begin
              fcount_next = fcount - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign occ_next = OCC_W'(SUM_W'(fcount_next) + SUM_W'(bcount_next));

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      PH_IDLE: begin
        if (start) begin
          state_next = PH_FINISH;
        end
      end
      PH_FINISH: begin
        state_next = PH_IDLE;
      end
      default: begin
        state_next = PH_IDLE;
      end
    endcase
  end

  // Sequencer outputs and front write port
  always_comb begin
    busy        = 1'b0;
    done        = 1'b0;
    front_we    = f_we0;
    front_waddr = f_waddr0;
    front_wdata = value;
    case (state)
      PH_IDLE: begin
      end
      PH_FINISH: begin
        busy        = 1'b1;
        done        = 1'b1;
        front_we    = pend_move;
        front_waddr = ftail;
        front_wdata = back_rdata;
      end
      default: begin
      end
    endcase
  end

  // Result fields
  assign popped_value = pend_pop ? front_rdata : '0;
  assign status       = status_q;
  assign occupancy    = occ_q;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_IDLE;
      fstart    <= '0;
      fcount    <= '0;
      bstart    <= '0;
      bcount    <= '0;
      pend_pop  <= 1'b0;
      pend_move <= 1'b0;
    end else begin
      state     <= state_next;
      fstart    <= fstart_next;
      fcount    <= fcount_next;
      bstart    <= bstart_next;
      bcount    <= bcount_next;
      pend_pop  <= pend_pop_next;
      pend_move <= pend_move_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ftail    <= ftail_next;
    status_q <= status_next;
    if (accept) begin
      occ_q <= occ_next;
    end
  end

endmodule
`default_nettype wire

### src/queue_with_middle_insert_top.sv
// Top level of the queue with middle insertion: two ring-half RAMs and their sequencer.
// The result of an accepted command is strobed by done in the cycle after it is accepted.
// The block is busy while it finishes a command and takes no new one until then; the head reads
//   of both ring RAMs are registered, and a moved element is written into the front ring in the finish phase.
// Reset: synchronous rst empties both halves; RAM contents are not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module queue_with_middle_insert_top #(
  parameter int CAPACITY = qmi_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [qmi_pkg::CMD_W-1:0]       command,
  input  wire logic signed [qmi_pkg::DATA_W-1:0] value,
  output logic                                 done,
  output logic signed [qmi_pkg::DATA_W-1:0]    popped_value,
  output logic [qmi_pkg::STATUS_W-1:0]         status,
  output logic [qmi_pkg::OCC_W-1:0]            occupancy
);

  import qmi_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  logic              front_we, back_we;
  logic [IDX_W-1:0]  front_waddr, front_raddr, back_waddr, back_raddr;
  logic [DATA_W-1:0] front_wdata, front_rdata, back_wdata, back_rdata;
  logic [DATA_W-1:0] popped_raw;

  assign popped_value = popped_raw;

  // Sequencer and ring pointers
  qmi_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .value        (value),
    .busy         (busy),
    .done         (done),
    .popped_value (popped_raw),
    .status       (status),
    .occupancy    (occupancy),
    .front_we     (front_we),
    .front_waddr  (front_waddr),
    .front_wdata  (front_wdata),
    .front_raddr  (front_raddr),
    .front_rdata  (front_rdata),
    .back_we      (back_we),
    .back_waddr   (back_waddr),
    .back_wdata   (back_wdata),
    .back_raddr   (back_raddr),
    .back_rdata   (back_rdata)
  );

  // Front half ring storage
  qmi_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_front_ram (
    .clk   (clk),
    .we    (front_we),
    .waddr (front_waddr),
    .wdata (front_wdata),
    .raddr (front_raddr),
    .rdata (front_rdata)
  );

  // Back half ring storage
  qmi_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_back_ram (
    .clk   (clk),
    .we    (back_we),
    .waddr (back_waddr),
    .wdata (back_wdata),
    .raddr (back_raddr),
    .rdata (back_rdata)
  );

endmodule
`default_nettype wire

### tb/queue_with_middle_insert_top_test.sv
// Self-checking testbench for the queue with middle insertion: directed and random commands.
`default_nettype none
module queue_with_middle_insert_top_test;
  import qmi_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;
  // Fourth command code: no operation
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // One expected result
  typedef struct {
    logic signed [DATA_W-1:0] popped_value;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } queue_result_t;

  // Predicts each result from its own copy of both ring halves and checks the DUT
  class queue_scoreboard;
    logic [DATA_W-1:0] front_ring [CAP];
    logic [DATA_W-1:0] back_ring [CAP];
    int unsigned front_start, front_count, back_start, back_count;
    queue_result_t pending_results [$];
    int unsigned mismatch_count;

    function new();
      front_start = 0;
      front_count = 0;
      back_start = 0;
      back_count = 0;
      mismatch_count = 0;
    endfunction

    // Keep the front half at ceil(L/2): move one back head to the front tail
    function void move_back_head_to_front();
      if (back_count > front_count) begin
        front_ring[(front_start + front_count) % CAP] = back_ring[back_start];
        front_count++;
        back_start = (back_start + 1) % CAP;
        back_count--;
      end
    endfunction

    // Accepted command: update the queue image and queue the expected result
    function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
      queue_result_t r;
      r.popped_value = '0;
      r.status = ST_OK;
      if (cmd == CMD_PUSH || cmd == CMD_INSERT) begin
        if (front_count + back_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          if (cmd == CMD_PUSH) begin
            back_ring[(back_start + back_count) % CAP] = val;
          end else begin
            back_start = (back_start + CAP - 1) % CAP;
            back_ring[back_start] = val;
          end
          back_count++;
          move_back_head_to_front();
        end
      end else if (cmd == CMD_POP) begin
        if (front_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = front_ring[front_start];
          front_start = (front_start + 1) % CAP;
          front_count--;
          move_back_head_to_front();
        end
      end
      r.occupancy = OCC_W'(front_count + back_count);
      pending_results.push_back(r);
    endfunction

    // Strobed result: compare with the oldest expectation
    function void check_result(logic signed [DATA_W-1:0] popped, logic [STATUS_W-1:0] st,
                               logic [OCC_W-1:0] occ);
      queue_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: popped=%0d status=%0d occupancy=%0d", popped, st, occ);
        return;
      end
      exp_r = pending_results.pop_front();
      if (popped !== exp_r.popped_value || st !== exp_r.status ||
          occ !== exp_r.occupancy) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("mismatch: popped %0d/%0d status %0d/%0d occupancy %0d/%0d (exp/act)",
                   exp_r.popped_value, popped, exp_r.status, st, exp_r.occupancy, occ);
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [CMD_W-1:0]         command = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] popped_value;
  logic [STATUS_W-1:0]      status;
  logic [OCC_W-1:0]         occupancy;

  queue_scoreboard board = new();
  int unsigned cycle_count = 0;
  // Entry count as seen by the stimulus, used to steer the fill phase
  int unsigned queued_entries = 0;

  queue_with_middle_insert_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .value        (value),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .occupancy    (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe accepted transactions and strobed results
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_command(command, value);
      if (done) board.check_result(popped_value, status, occupancy);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly random values, with the signed extremes now and then
  function automatic logic [DATA_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return 32'h8000_0000;
    if (r < 6) return 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int unsigned w_push, int unsigned w_insert,
                                                    int unsigned w_pop);
    int unsigned r;
    r = $urandom_range(99);
    if (r < w_push) return CMD_PUSH;
    if (r < w_push + w_insert) return CMD_INSERT;
    if (r < w_push + w_insert + w_pop) return CMD_POP;
    return CMD_NOP;
  endfunction

  // Issue one transaction after random idle cycles; returns once it is accepted
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val,
                              int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      command <= CMD_W'($urandom);
      value <= $urandom;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ((cmd == CMD_PUSH || cmd == CMD_INSERT) && queued_entries < CAP) queued_entries++;
    else if (cmd == CMD_POP && queued_entries > 0) queued_entries--;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop, no-op, insert into empty, extremes, middle inserts, drain
    send_command(CMD_POP, 32'h1234_5678, 0);
    send_command(CMD_NOP, 32'hA5A5_5A5A, 0);
    send_command(CMD_INSERT, 32'h7FFF_FFFF, 0);
    send_command(CMD_POP, 32'h0, 0);
    send_command(CMD_PUSH, 32'h8000_0000, 0);
    send_command(CMD_PUSH, 32'h7FFF_FFFF, 0);
    send_command(CMD_INSERT, 32'h0, 0);
    send_command(CMD_INSERT, 32'hFFFF_FFFF, 0);
    send_command(CMD_PUSH, 32'h1, 0);
    send_command(CMD_INSERT, 32'h2, 0);
    send_command(CMD_NOP, 32'hFFFF_FFFF, 0);
    send_command(CMD_INSERT, 32'h3, 0);
    repeat (7) send_command(CMD_POP, 32'hFFFF_FFFF, 0);
    send_command(CMD_POP, 32'h0, 0);
    send_command(CMD_NOP, 32'h0, 0);

    // Random walk around small fill levels, sender idles 30%
    repeat (250) send_command(pick_command(35, 30, 30), random_value(), 30);
    wait_drained();

    // Fill to capacity and keep pushing against it, sender idles 54%
    while (queued_entries < CAP) send_command(pick_command(47, 47, 4), random_value(), 54);
    repeat (40) send_command(pick_command(45, 45, 6), random_value(), 54);
    wait_drained();

    // Pop-heavy traffic back to back
    repeat (200) send_command(pick_command(18, 17, 60), random_value(), 0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
src/qmi_pkg.sv
src/qmi_ram.sv
src/qmi_ctrl.sv
src/queue_with_middle_insert_top.sv
tb/queue_with_middle_insert_top_test.sv
